FILE: rtl/bandlimited_impulse_train_macros.svh
// assertion macros for the impulse train controller
`ifndef BANDLIMITED_IMPULSE_TRAIN_MACROS_SVH
`define BANDLIMITED_IMPULSE_TRAIN_MACROS_SVH

// condition holds in the same cycle
`define BLIT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the next cycle
`define BLIT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/blit_pkg.sv
// types and constants of the band-limited impulse train
package blit_pkg;

   localparam int PHASE_W    = 34;
   localparam int RATE_W     = 18;
   localparam int ZCS_W      = 11;
   localparam int ADDR_IN_W  = 16;
   localparam int WORD_W     = 18;
   localparam int OUT_W      = 24;
   localparam int POS_W      = 22;
   localparam int POS_FRAC   = 15;
   localparam int IDX_W      = 18;
   localparam int INTERP_W   = 36;
   localparam int TERM_W     = 53;
   localparam int ACC_W      = 58;
   localparam int GAIN_Q16   = 58327;
   localparam int DIV_STEPS  = 15;
   localparam int DRAIN_CYCLES = 10;
   localparam int LOAD_CYCLES  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZCS         = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BANDLIMIT   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_PHASE,
      ST_UPDATE,
      ST_DIV,
      ST_WALK,
      ST_DRAIN,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic ld_issue;
      logic phase_add;
      logic phase_upd;
      logic div_init;
      logic div_step;
      logic walk_issue;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic bandlimit;
      logic wrapped;
   } dp_status_type;

endpackage

FILE: rtl/blit_datapath.sv
// phase accumulator, offset divider, pulse slot pipeline and sinc table
module blit_datapath import blit_pkg::*; #(
   parameter int ZERO_CROSSINGS = 64,
   parameter int TABLE_DEPTH = 65536,
   localparam int SLOTS = ZERO_CROSSINGS / 2,
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dp_cmd_type                   cmd,
   input  logic [SLOT_W-1:0]            issue_slot,
   output dp_status_type                status,
   input  logic [PHASE_W-1:0]           req_freq_inc,
   input  logic [ADDR_IN_W-1:0]         req_table_addr,
   input  logic signed [WORD_W-1:0]     req_table_word,
   output logic signed [OUT_W-1:0]      rsp_sample,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int MOD_SH = IDX_W + AW;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << MOD_SH) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
   localparam int RECIP_W = IDX_W + 2;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
   localparam int MODP_W = IDX_W + RECIP_W;
   localparam int QD_W = 2 * IDX_W;
   localparam int POS_X_W = POS_W + 1;
   localparam int LEN_W = IDX_W + 1;
   localparam logic [POS_X_W-1:0] POS_ONE = POS_X_W'(1) << POS_FRAC;
   localparam logic [POS_X_W-1:0] POS_LIMIT = POS_X_W'(ZERO_CROSSINGS - 1) << POS_FRAC;
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << 30;
   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(8388607);
   localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(8388608);
   localparam logic signed [OUT_W-1:0] ALIAS_ONE = OUT_W'(65536);

   // configuration
   logic [RATE_W-1:0] rate_ff;
   logic [ZCS_W-1:0]  zcs_ff;
   logic              bl_ff;

   // item and phase
   logic [PHASE_W-1:0]        inc_ff;
   logic [ADDR_IN_W-1:0]      addr_ff;
   logic signed [WORD_W-1:0]  word_ff;
   logic [PHASE_W-1:0]        acc_ff;
   logic [PHASE_W:0]          ph_ff;
   logic [PHASE_W:0]          diff_ff;
   logic                      wrapped_ff;

   // offset divider
   logic [PHASE_W:0]          rem_ff;
   logic [POS_FRAC-1:0]       q_ff;
   logic                      clamp_ff;
   logic                      zinc_ff;
   logic                      pend_ff;

   // pulse slots
   logic                      act_ff [SLOTS];
   logic [POS_W-1:0]          pos_mem [SLOTS];

   // slot pipeline
   logic                      p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff, p5_v_ff;
   logic                      p6_v_ff, p7_v_ff, p8_v_ff, p9_v_ff;
   logic                      p3_ld_ff, p4_ld_ff, p5_ld_ff;
   logic [POS_W-1:0]          p1_pos_ff;
   logic                      p1_act_ff;
   logic [SLOT_W-1:0]         p1_slot_ff;
   logic [2*ZCS_W+POS_W-ZCS_W-1:0] p2_scaled_ff;
   logic [IDX_W-1:0]          p3_idx_ff, p3_next_ff, p4_idx_ff, p4_next_ff;
   logic [IDX_W-1:0]          p4_qi_ff, p4_qn_ff;
   logic [POS_FRAC-1:0]       p3_eta_ff, p4_eta_ff, p5_eta_ff, p6_eta_ff;
   logic [AW-1:0]             p5_ai_ff, p5_an_ff;
   logic signed [WORD_W-1:0]  tbl [TABLE_DEPTH];
   logic signed [WORD_W-1:0]  p6_ti_ff, p6_tn_ff;
   logic signed [WORD_W+16:0] p7_a_ff, p7_b_ff;
   logic signed [INTERP_W-1:0] p8_interp_ff;
   logic signed [TERM_W-1:0]  p9_term_ff;
   logic signed [ACC_W-1:0]   sum_ff;
   logic signed [OUT_W-1:0]   sample_ff;

   // combinational
   logic [PHASE_W-1:0]        thresh;
   logic                      wrap;
   logic [PHASE_W:0]          phn;
   logic [PHASE_W+1:0]        r2;
   logic [PHASE_W+1:0]        inc_x;
   logic [POS_FRAC-1:0]       off;
   logic                      use_ins;
   logic                      eff_act;
   logic [POS_W-1:0]          eff_pos;
   logic [POS_X_W-1:0]        npos;
   logic [IDX_W-1:0]          s_idx;
   logic [LEN_W-1:0]          s_x, s_len, s_m, s_next;
   logic [MODP_W-1:0]         prod_i, prod_n;
   logic [QD_W-1:0]           qd_i, qd_n, r_i, r_n;
   logic [15:0]               w_i;
   logic signed [ACC_W-1:0]   rsum, rsh;
   logic signed [OUT_W-1:0]   sat;

   assign csr_ready = 1'b1;
   assign status.bandlimit = bl_ff;
   assign status.wrapped = wrapped_ff;
   assign rsp_sample = sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_W'(48000);
         zcs_ff <= ZCS_W'(1024);
         bl_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SAMPLE_RATE: rate_ff <= csr_wdata[RATE_W-1:0];
            CSR_ZCS: zcs_ff <= csr_wdata[ZCS_W-1:0];
            CSR_BANDLIMIT: bl_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // phase update and wrap
   always_comb begin
      thresh = {rate_ff, 16'b0};
      wrap = ph_ff >= {1'b0, thresh};
      phn = wrap ? ph_ff - {1'b0, thresh} : ph_ff;
      r2 = {rem_ff, 1'b0};
      inc_x = {2'b0, inc_ff};
      off = zinc_ff ? '0 : (clamp_ff ? '1 : q_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         inc_ff <= req_freq_inc;
         addr_ff <= req_table_addr;
         word_ff <= req_table_word;
      end
      if (cmd.phase_add) begin
         ph_ff <= {1'b0, acc_ff} + {1'b0, inc_ff};
      end
      if (cmd.phase_upd) begin
         diff_ff <= ph_ff - {1'b0, thresh};
         wrapped_ff <= wrap;
      end
      if (cmd.div_init) begin
         rem_ff <= diff_ff;
         q_ff <= '0;
         clamp_ff <= diff_ff >= {1'b0, inc_ff};
         zinc_ff <= inc_ff == '0;
      end else if (cmd.div_step) begin
         if (r2 >= inc_x) begin
            rem_ff <= (PHASE_W+1)'(r2 - inc_x);
            q_ff <= {q_ff[POS_FRAC-2:0], 1'b1};
         end else begin
            rem_ff <= r2[PHASE_W:0];
            q_ff <= {q_ff[POS_FRAC-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.phase_upd) begin
         acc_ff <= phn[PHASE_W] ? '1 : phn[PHASE_W-1:0];
      end
   end

   // slot read and write-back
   always_comb begin
      use_ins = p1_v_ff && !p1_act_ff && pend_ff;
      eff_act = p1_act_ff || use_ins;
      eff_pos = p1_act_ff ? p1_pos_ff : POS_W'(off);
      npos = {1'b0, eff_pos} + POS_ONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            act_ff[i] <= 1'b0;
         end
      end else begin
         if (cmd.div_init) begin
            pend_ff <= wrapped_ff;
         end else if (use_ins) begin
            pend_ff <= 1'b0;
         end
         if (p1_v_ff && eff_act) begin
            act_ff[p1_slot_ff] <= npos <= POS_LIMIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p1_v_ff && eff_act) begin
         pos_mem[p1_slot_ff] <= npos[POS_W-1:0];
      end
      p1_pos_ff <= pos_mem[issue_slot];
      p1_act_ff <= act_ff[issue_slot];
      p1_slot_ff <= issue_slot;
   end

   // table index, next index and modulo by the table depth
   always_comb begin
      s_idx = p2_scaled_ff[POS_FRAC +: IDX_W];
      s_x = {1'b0, s_idx} + LEN_W'(1);
      s_len = LEN_W'(LEN_W'(ZERO_CROSSINGS) * {{(LEN_W-ZCS_W){1'b0}}, zcs_ff});
      s_m = s_len - LEN_W'(1);
      if (s_len <= LEN_W'(1) || s_m == LEN_W'(1)) begin
         s_next = '0;
      end else if (s_x >= s_m) begin
         s_next = s_x - s_m;
      end else begin
         s_next = s_x;
      end
      prod_i = MODP_W'(p3_idx_ff) * MODP_W'(RECIP);
      prod_n = MODP_W'(p3_next_ff) * MODP_W'(RECIP);
      qd_i = QD_W'(p4_qi_ff) * QD_W'(TABLE_DEPTH);
      qd_n = QD_W'(p4_qn_ff) * QD_W'(TABLE_DEPTH);
      r_i = QD_W'(p4_idx_ff) - qd_i;
      r_n = QD_W'(p4_next_ff) - qd_n;
      w_i = 16'h8000 - {1'b0, p6_eta_ff};
   end

   always_ff @(posedge clock) begin
      p2_scaled_ff <= eff_pos * zcs_ff;
      if (cmd.ld_issue) begin
         p3_idx_ff <= IDX_W'(addr_ff);
      end else begin
         p3_idx_ff <= s_idx;
      end
      p3_next_ff <= s_next[IDX_W-1:0];
      p3_eta_ff <= p2_scaled_ff[POS_FRAC-1:0];
      p4_qi_ff <= IDX_W'(prod_i >> MOD_SH);
      p4_qn_ff <= IDX_W'(prod_n >> MOD_SH);
      p4_idx_ff <= p3_idx_ff;
      p4_next_ff <= p3_next_ff;
      p4_eta_ff <= p3_eta_ff;
      p5_ai_ff <= r_i[AW-1:0];
      p5_an_ff <= r_n[AW-1:0];
      p5_eta_ff <= p4_eta_ff;
      p6_eta_ff <= p5_eta_ff;
      p7_a_ff <= p6_ti_ff * $signed({1'b0, w_i});
      p7_b_ff <= p6_tn_ff * $signed({2'b0, p6_eta_ff});
      p8_interp_ff <= INTERP_W'(p7_a_ff) + INTERP_W'(p7_b_ff);
      p9_term_ff <= p8_interp_ff * $signed(17'(GAIN_Q16));
   end

   always_ff @(posedge clock) begin
      if (p5_ld_ff) begin
         tbl[p5_ai_ff] <= word_ff;
      end
      p6_ti_ff <= tbl[p5_ai_ff];
      p6_tn_ff <= tbl[p5_an_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
         p5_v_ff <= 1'b0;
         p6_v_ff <= 1'b0;
         p7_v_ff <= 1'b0;
         p8_v_ff <= 1'b0;
         p9_v_ff <= 1'b0;
         p3_ld_ff <= 1'b0;
         p4_ld_ff <= 1'b0;
         p5_ld_ff <= 1'b0;
      end else begin
         p1_v_ff <= cmd.walk_issue;
         p2_v_ff <= p1_v_ff && eff_act;
         p3_v_ff <= p2_v_ff && !cmd.ld_issue;
         p4_v_ff <= p3_v_ff;
         p5_v_ff <= p4_v_ff;
         p6_v_ff <= p5_v_ff;
         p7_v_ff <= p6_v_ff;
         p8_v_ff <= p7_v_ff;
         p9_v_ff <= p8_v_ff;
         p3_ld_ff <= cmd.ld_issue;
         p4_ld_ff <= p3_ld_ff;
         p5_ld_ff <= p4_ld_ff;
      end
   end

   // accumulate, round and saturate
   always_comb begin
      rsum = sum_ff + RND_HALF;
      rsh = rsum >>> 31;
      if (rsh > SAT_MAX) begin
         sat = SAT_MAX[OUT_W-1:0];
      end else if (rsh < SAT_MIN) begin
         sat = SAT_MIN[OUT_W-1:0];
      end else begin
         sat = rsh[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.phase_upd) begin
         sum_ff <= '0;
      end else if (p9_v_ff) begin
         sum_ff <= sum_ff + ACC_W'(p9_term_ff);
      end
      if (cmd.out_load) begin
         if (bl_ff) begin
            sample_ff <= sat;
         end else begin
            sample_ff <= wrapped_ff ? ALIAS_ONE : '0;
         end
      end
   end

endmodule

FILE: rtl/blit_ctrl.sv
// sequencer for load and sample items
`include "bandlimited_impulse_train_macros.svh"
module blit_ctrl import blit_pkg::*; #(
   parameter int ZERO_CROSSINGS = 64,
   localparam int SLOTS = ZERO_CROSSINGS / 2,
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_func,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dp_cmd_type        cmd,
   output logic [SLOT_W-1:0] issue_slot,
   input  dp_status_type     status
);

   localparam int CNT_W = $clog2(SLOTS + DIV_STEPS + DRAIN_CYCLES + 1);
   localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(SLOTS - 1);

   ctrl_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      req_stall = 1'b1;
      issue_slot = cnt_ff[SLOT_W-1:0];
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cnt_in = '0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = req_func ? ST_PHASE : ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.ld_issue = cnt_ff == '0;
            if (cnt_ff == CNT_W'(LOAD_CYCLES)) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_PHASE: begin
            cmd.phase_add = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.phase_upd = 1'b1;
            cnt_in = '0;
            state_in = status.bandlimit ? ST_DIV : ST_FINISH;
         end
         ST_DIV: begin
            cmd.div_init = cnt_ff == '0;
            cmd.div_step = cnt_ff != '0;
            if (cnt_ff == CNT_W'(DIV_STEPS)) begin
               cnt_in = '0;
               state_in = ST_WALK;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_WALK: begin
            cmd.walk_issue = 1'b1;
            if (cnt_ff == LAST_SLOT) begin
               cnt_in = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (cnt_ff == CNT_W'(DRAIN_CYCLES - 1)) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `BLIT_ASSERT_NEXT(a_walk_to_drain, clock, reset, state_ff == ST_WALK && cnt_ff == LAST_SLOT, state_ff == ST_DRAIN, "slot walk did not end in drain")
   `BLIT_ASSERT_IMPLY(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH, "result raised outside finish")
   `BLIT_ASSERT_IMPLY(a_div_bound, clock, reset, state_ff == ST_DIV, cnt_ff <= CNT_W'(DIV_STEPS), "divider step count overran")
   `BLIT_ASSERT_IMPLY(a_no_overwrite, clock, reset, cmd.out_load, !rsp_valid_ff || !rsp_stall, "pending result overwritten")

endmodule

FILE: rtl/bandlimited_impulse_train.sv
// band-limited impulse train oscillator, top level
// Input channel req_*: func 0 writes req_table_word into the sinc table at
// req_table_addr and returns no result; func 1 advances one output sample
// by req_freq_inc and returns exactly one rsp_sample.
// Configuration csr_*: sample rate, table entries per zero crossing and
// band-limit enable, written while no item is in flight; csr_ready is high.
// The user must keep to that; the block itself does not enforce it.
// A sample item in band-limited mode runs phase update, a 15 step offset
// divider, one pulse slot per cycle through the interpolation pipeline,
// then pipeline drain.
// In aliased mode a sample item skips the divider, slot walk and drain.
// The result sits in an output register; the next item is taken while it
// waits. If rsp_stall holds it past the next sample item's end, that item
// waits in its final step until the result is transferred.
// Reset clears the phase, all pulse slots and the configuration to 48000,
// 1024 and band-limited; the sinc table is not cleared and must be loaded.
module bandlimited_impulse_train import blit_pkg::*; #(
   parameter int ZERO_CROSSINGS = 64,
   parameter int TABLE_DEPTH = 65536
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_func,
   input  logic [PHASE_W-1:0]        req_freq_inc,
   input  logic [ADDR_IN_W-1:0]      req_table_addr,
   input  logic signed [WORD_W-1:0]  req_table_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [OUT_W-1:0]   rsp_sample,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SLOTS = ZERO_CROSSINGS / 2;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   dp_cmd_type        cmd;
   dp_status_type     status;
   logic [SLOT_W-1:0] issue_slot;

   blit_ctrl #(
      .ZERO_CROSSINGS(ZERO_CROSSINGS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_func(req_func),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd(cmd),
      .issue_slot(issue_slot),
      .status(status)
   );

   blit_datapath #(
      .ZERO_CROSSINGS(ZERO_CROSSINGS),
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .issue_slot(issue_slot),
      .status(status),
      .req_freq_inc(req_freq_inc),
      .req_table_addr(req_table_addr),
      .req_table_word(req_table_word),
      .rsp_sample(rsp_sample),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

endmodule
